/* rtl/core/crt_pkg.sv */
// Shared types, register codes and reset values for the countdown reminder timer.
package crt_pkg;

    // Mode codes as seen on the result beat
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_COUNTING = 2'd1,
        MODE_ALARM    = 2'd2
    } crt_mode_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_MIN_MINUTES      = 2'd0,
        REG_MAX_MINUTES      = 2'd1,
        REG_TICKS_PER_SECOND = 2'd2,
        REG_DEBOUNCE_TICKS   = 2'd3
    } crt_reg_idx_t;

    localparam int unsigned CfgAddrW = 4;

    localparam logic [6:0]  RstMinMinutes     = 7'd10;
    localparam logic [6:0]  RstMaxMinutes     = 7'd60;
    localparam logic [15:0] RstTicksPerSecond = 16'd1000;
    localparam logic [7:0]  RstDebounceTicks  = 8'd20;
    localparam logic [6:0]  RstChosenMinutes  = 7'd15;
    localparam logic [5:0]  LastSecond        = 6'd59;

    // Input beat: one poll tick
    typedef struct packed {
        logic [15:0] encoder_count;
        logic        button_pressed;
    } crt_in_t;

    // Result beat
    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] set_minutes;
        logic [6:0] countdown_minutes;
        logic [5:0] countdown_seconds;
        logic       buzzer_on;
    } crt_out_t;

    // Configuration handed to the update logic
    typedef struct packed {
        logic [6:0]  min_minutes;
        logic [6:0]  max_minutes;
        logic [15:0] ticks_per_second;
        logic [7:0]  debounce_ticks;
    } crt_cfg_t;

    // Timer state; the remaining time is kept as minutes and seconds
    typedef struct packed {
        crt_mode_t   mode;
        logic [6:0]  chosen_minutes;
        logic [6:0]  left_minutes;
        logic [5:0]  left_seconds;
        logic [15:0] previous_encoder;
        logic [15:0] since_second;
        logic [7:0]  since_press;
    } crt_state_t;

endpackage

/* rtl/core/countdown_reminder_timer.sv */
// Countdown reminder timer top level: beat registers, timer state and config port.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  tick     | tick_valid / tick_stall      | tick   (encoder_count, button)
//  status   | status_valid / status_stall  | status (mode, time, buzzer)
//  config   | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// One tick beat per cycle while tick_stall is low; each beat gives one status beat
// through the input register, then update logic into the result register.
// The update of one tick is a single pass of compare/add logic on the state.
// Reset puts the timer in idle with 15 chosen minutes and the default config.
// A stalled status beat holds; the tick side keeps taking beats until both
// registers are full.
module countdown_reminder_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  crt_pkg::crt_in_t              tick,
    output logic                          status_valid,
    input  logic                          status_stall,
    output crt_pkg::crt_out_t             status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crt_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import crt_pkg::*;

    crt_cfg_t   cfg;
    crt_in_t    tick_reg;
    logic       tick_valid_reg;
    crt_out_t   status_reg;
    crt_out_t   status_next;
    logic       status_valid_reg;
    crt_state_t state_reg;
    crt_state_t state_next;
    logic       advance;
    logic       accept;

    crt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crt_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .tick       (tick_reg),
        .state_next (state_next),
        .result     (status_next)
    );

    // Handshake control
    assign advance      = tick_valid_reg && (!status_valid_reg || !status_stall);
    assign tick_stall   = tick_valid_reg && !advance;
    assign accept       = tick_valid && !tick_stall;
    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                tick_valid_reg <= 1'b1;
            else if (advance)
                tick_valid_reg <= 1'b0;

            if (advance)
                status_valid_reg <= 1'b1;
            else if (!status_stall)
                status_valid_reg <= 1'b0;
        end
    end

    // Beat payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            tick_reg <= tick;
        if (advance)
            status_reg <= status_next;
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= MODE_IDLE;
            state_reg.chosen_minutes   <= RstChosenMinutes;
            state_reg.left_minutes     <= 7'd0;
            state_reg.left_seconds     <= 6'd0;
            state_reg.previous_encoder <= 16'd0;
            state_reg.since_second     <= 16'd0;
            state_reg.since_press      <= 8'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Checks
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_IDLE |->
            state_reg.left_minutes == 7'd0 && state_reg.left_seconds == 6'd0)
        else $error("idle with remaining time");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.left_seconds <= LastSecond)
        else $error("seconds out of range");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a tick");

    a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid_reg |-> status_reg.buzzer_on == (status_reg.mode == MODE_ALARM))
        else $error("buzzer disagrees with mode");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> status_valid_reg)
        else $error("tick lost its status beat");

endmodule

/* rtl/core/crt_cfg_regs.sv */
// APB-style configuration registers of the countdown reminder timer.
module crt_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crt_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output crt_pkg::crt_cfg_t             cfg
);
    import crt_pkg::*;

    crt_cfg_t     cfg_reg;
    crt_reg_idx_t idx;
    logic         wr_en;

    assign pready = 1'b1;
    assign idx    = crt_reg_idx_t'(paddr[CfgAddrW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_minutes      <= RstMinMinutes;
            cfg_reg.max_minutes      <= RstMaxMinutes;
            cfg_reg.ticks_per_second <= RstTicksPerSecond;
            cfg_reg.debounce_ticks   <= RstDebounceTicks;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MIN_MINUTES:      cfg_reg.min_minutes      <= pwdata[6:0];
                REG_MAX_MINUTES:      cfg_reg.max_minutes      <= pwdata[6:0];
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= pwdata[15:0];
                REG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_MIN_MINUTES:      prdata = {25'd0, cfg_reg.min_minutes};
            REG_MAX_MINUTES:      prdata = {25'd0, cfg_reg.max_minutes};
            REG_TICKS_PER_SECOND: prdata = {16'd0, cfg_reg.ticks_per_second};
            REG_DEBOUNCE_TICKS:   prdata = {24'd0, cfg_reg.debounce_ticks};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/core/crt_step.sv */
// Per-tick update of the timer state and the matching result beat.
module crt_step (
    input  crt_pkg::crt_cfg_t   cfg,
    input  crt_pkg::crt_state_t state,
    input  crt_pkg::crt_in_t    tick,
    output crt_pkg::crt_state_t state_next,
    output crt_pkg::crt_out_t   result
);
    import crt_pkg::*;

    logic [15:0] diff;
    logic [15:0] sec_cnt;
    logic [7:0]  press_cnt;
    crt_mode_t   mode_a;

    // Next state: counters, encoder, button, then countdown
    always_comb
    begin
        state_next = state;

        // tick counters saturate at their limits
        sec_cnt   = (state.since_second < cfg.ticks_per_second) ?
                    state.since_second + 16'd1 : state.since_second;
        press_cnt = (state.since_press < cfg.debounce_ticks) ?
                    state.since_press + 8'd1 : state.since_press;
        state_next.since_second = sec_cnt;
        state_next.since_press  = press_cnt;

        // encoder steps the chosen time only in idle
        diff = tick.encoder_count - state.previous_encoder;
        if (state.mode == MODE_IDLE && diff != 16'd0)
        begin
            if (!diff[15])
            begin
                if (state.chosen_minutes < cfg.max_minutes)
                    state_next.chosen_minutes = state.chosen_minutes + 7'd1;
            end
            else if (state.chosen_minutes > cfg.min_minutes)
            begin
                state_next.chosen_minutes = state.chosen_minutes - 7'd1;
            end
            state_next.previous_encoder = tick.encoder_count;
        end

        // accepted press starts or cancels the countdown
        if (tick.button_pressed && press_cnt >= cfg.debounce_ticks)
        begin
            state_next.since_press = 8'd0;
            if (state.mode == MODE_IDLE)
            begin
                state_next.mode         = MODE_COUNTING;
                state_next.left_minutes = state_next.chosen_minutes;
                state_next.left_seconds = 6'd0;
            end
            else
            begin
                state_next.mode         = MODE_IDLE;
                state_next.left_minutes = 7'd0;
                state_next.left_seconds = 6'd0;
            end
        end
        mode_a = state_next.mode;

        // one countdown step per second boundary
        if (mode_a == MODE_COUNTING && sec_cnt >= cfg.ticks_per_second)
        begin
            state_next.since_second = 16'd0;
            if (state_next.left_seconds != 6'd0)
            begin
                state_next.left_seconds = state_next.left_seconds - 6'd1;
            end
            else if (state_next.left_minutes != 7'd0)
            begin
                state_next.left_minutes = state_next.left_minutes - 7'd1;
                state_next.left_seconds = LastSecond;
            end
            else
            begin
                state_next.mode = MODE_ALARM;
            end
        end
    end

    // Result fields from the updated state
    always_comb
    begin
        result.mode              = state_next.mode;
        result.set_minutes       = state_next.chosen_minutes;
        result.countdown_minutes = state_next.left_minutes;
        result.countdown_seconds = state_next.left_seconds;
        result.buzzer_on         = (state_next.mode == MODE_ALARM);
    end

endmodule
